FILE: rtl/fps_pkg.sv
// force profile sequencer package
// shared widths, reset values, register indexes, phase codes and types
// no dependencies
package fps_pkg;

  localparam int TARGET_W        = 23;
  localparam int HALF_W          = TARGET_W - 1;
  localparam int REG_W           = 16;
  localparam int PHASE_W         = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = TARGET_W;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int RAMP_STEPS_DEF  = 20;

  localparam logic [REG_W-1:0] START_DELAY_RST  = 16'd10;
  localparam logic [REG_W-1:0] SETTLE_DELAY_RST = 16'd5;
  localparam logic [REG_W-1:0] HALF_HOLD_RST    = 16'd20;
  localparam logic [REG_W-1:0] FULL_HOLD_RST    = 16'd40;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORCE_TARGET = 3'd0,
    REG_START_DELAY  = 3'd1,
    REG_SETTLE_DELAY = 3'd2,
    REG_HALF_HOLD    = 3'd3,
    REG_FULL_HOLD    = 3'd4
  } reg_idx_t;

  // profile phases
  localparam logic [PHASE_W-1:0] PH_START     = 4'd0;
  localparam logic [PHASE_W-1:0] PH_HALF_HOLD = 4'd1;
  localparam logic [PHASE_W-1:0] PH_RISE      = 4'd2;
  localparam logic [PHASE_W-1:0] PH_FULL_HOLD = 4'd3;
  localparam logic [PHASE_W-1:0] PH_FALL      = 4'd4;
  localparam logic [PHASE_W-1:0] PH_HALF_WAIT = 4'd5;
  localparam logic [PHASE_W-1:0] PH_RAMP_DOWN = 4'd6;
  localparam logic [PHASE_W-1:0] PH_ZERO_HOLD = 4'd7;
  localparam logic [PHASE_W-1:0] PH_RAMP_UP   = 4'd8;

  typedef struct packed {
    logic [TARGET_W-1:0] force_target;
    logic [REG_W-1:0]    start_delay;
    logic [REG_W-1:0]    settle_delay;
    logic [REG_W-1:0]    half_hold;
    logic [REG_W-1:0]    full_hold;
  } cfg_t;

  typedef struct packed {
    logic [TARGET_W-1:0] force_setpoint;
    logic [PHASE_W-1:0]  phase;
    logic                speed_load;
  } res_t;

endpackage

FILE: rtl/fps_cfg_regs.sv
// configuration registers and ramp step of the force profile sequencer
// step = (force_target >> 1) / RAMP_STEPS by reciprocal multiply; uses fps_pkg
module fps_cfg_regs import fps_pkg::*; #(
  parameter int RAMP_STEPS = RAMP_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg,
  output logic [HALF_W-1:0]     step
);

  // floor(x / R) = (x * ceil(2^(N+l) / R)) >> (N+l) for x < 2^N, l = ceil(log2 R)
  localparam int RECIP_SHIFT = HALF_W + $clog2(RAMP_STEPS);
  localparam int RECIP_W     = HALF_W + 2;
  localparam int PROD_W      = RECIP_SHIFT + HALF_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic [HALF_W-1:0] wr_half;
  logic [PROD_W-1:0] wr_prod;

  assign wr_half = cfg_data[TARGET_W-1:1];
  assign wr_prod = PROD_W'(wr_half) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.force_target <= '0;
      cfg.start_delay  <= START_DELAY_RST;
      cfg.settle_delay <= SETTLE_DELAY_RST;
      cfg.half_hold    <= HALF_HOLD_RST;
      cfg.full_hold    <= FULL_HOLD_RST;
      step             <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FORCE_TARGET: begin
          cfg.force_target <= cfg_data[TARGET_W-1:0];
          step             <= wr_prod[RECIP_SHIFT +: HALF_W];
        end
        REG_START_DELAY:  cfg.start_delay  <= cfg_data[REG_W-1:0];
        REG_SETTLE_DELAY: cfg.settle_delay <= cfg_data[REG_W-1:0];
        REG_HALF_HOLD:    cfg.half_hold    <= cfg_data[REG_W-1:0];
        REG_FULL_HOLD:    cfg.full_hold    <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/fps_seq_core.sv
// phase sequencer of the force profile: phase, tick counter and setpoint
// one tick per accepted word, next result formed combinationally; uses fps_pkg
module fps_seq_core import fps_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int RAMP_STEPS  = RAMP_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              motor_busy,
  input  cfg_t              cfg,
  input  logic [HALF_W-1:0] step,
  output res_t              res
);

  localparam int CMP_W   = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
  // ramp phases always enter with a cleared count and leave at RAMP_STEPS
  localparam int RAMP_W  = $clog2(RAMP_STEPS + 1);
  localparam int TOTAL_W = HALF_W + RAMP_W;

  logic [PHASE_W-1:0]     profile_phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, count_inc, tick_count_next;
  logic [TARGET_W-1:0]    setpoint_reg, setpoint_next;
  logic                   speed_next, phase_change;
  logic [HALF_W-1:0]      half;
  logic [TOTAL_W-1:0]     total;
  logic                   total_over, ramp_done;
  logic [CMP_W-1:0]       cnt_cmp;

  assign half       = cfg.force_target[TARGET_W-1:1];
  assign count_inc  = tick_count + COUNT_WIDTH'(1);
  assign cnt_cmp    = CMP_W'(count_inc);
  assign total      = TOTAL_W'(step) * TOTAL_W'(count_inc[RAMP_W-1:0]);
  assign total_over = total > TOTAL_W'(half);
  assign ramp_done  = count_inc >= COUNT_WIDTH'(RAMP_STEPS);

  always_comb begin
    phase_next    = profile_phase;
    setpoint_next = setpoint_reg;
    speed_next    = 1'b0;
    phase_change  = 1'b0;
    case (profile_phase)
      PH_START: begin
        setpoint_next = TARGET_W'(half);
        if (!motor_busy && cnt_cmp > CMP_W'(cfg.start_delay)) begin
          speed_next   = 1'b1;
          phase_next   = PH_HALF_HOLD;
          phase_change = 1'b1;
        end
      end
      PH_HALF_HOLD: begin
        if (cnt_cmp >= CMP_W'(cfg.half_hold)) begin
          setpoint_next = cfg.force_target;
          phase_next    = PH_RISE;
          phase_change  = 1'b1;
        end
      end
      PH_RISE: begin
        if (!motor_busy && cnt_cmp > CMP_W'(cfg.settle_delay)) begin
          phase_next   = PH_FULL_HOLD;
          phase_change = 1'b1;
        end
      end
      PH_FULL_HOLD: begin
        if (cnt_cmp >= CMP_W'(cfg.full_hold)) begin
          setpoint_next = TARGET_W'(half);
          phase_next    = PH_FALL;
          phase_change  = 1'b1;
        end
      end
      PH_FALL: begin
        if (!motor_busy && cnt_cmp > CMP_W'(cfg.settle_delay)) begin
          phase_next   = PH_HALF_WAIT;
          phase_change = 1'b1;
        end
      end
      PH_HALF_WAIT: begin
        if (cnt_cmp >= CMP_W'(cfg.half_hold)) begin
          phase_next   = PH_RAMP_DOWN;
          phase_change = 1'b1;
        end
      end
      PH_RAMP_DOWN: begin
        setpoint_next = total_over ? '0 : TARGET_W'(half - total[HALF_W-1:0]);
        if (ramp_done) begin
          setpoint_next = '0;
          phase_next    = PH_ZERO_HOLD;
          phase_change  = 1'b1;
        end
      end
      PH_ZERO_HOLD: begin
        if (cnt_cmp >= CMP_W'(cfg.half_hold)) begin
          phase_next   = PH_RAMP_UP;
          phase_change = 1'b1;
        end
      end
      PH_RAMP_UP: begin
        setpoint_next = total_over ? TARGET_W'(half) : TARGET_W'(total[HALF_W-1:0]);
        if (ramp_done) begin
          setpoint_next = TARGET_W'(half);
          phase_next    = PH_HALF_HOLD;
          phase_change  = 1'b1;
        end
      end
      default: ;
    endcase
    tick_count_next = phase_change ? '0 : count_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      profile_phase <= PH_START;
      tick_count    <= '0;
      setpoint_reg  <= '0;
    end else if (accept) begin
      profile_phase <= phase_next;
      tick_count    <= tick_count_next;
      setpoint_reg  <= setpoint_next;
    end
  end

  assign res.force_setpoint = setpoint_next;
  assign res.phase          = phase_next;
  assign res.speed_load     = speed_next;

endmodule

FILE: rtl/fps_out_skid.sv
// output register with skid stage for result words
// stall toward the input side comes from a flop only; uses fps_pkg
module fps_out_skid import fps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  logic main_valid, skid_valid;
  res_t main_data, skid_data;
  logic pop;

  assign pop = main_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          main_data  <= skid_data;
          skid_valid <= 1'b0;
        end else if (push) begin
          main_data <= push_data;
        end else begin
          main_valid <= 1'b0;
        end
      end else if (push) begin
        if (!main_valid) begin
          main_data  <= push_data;
          main_valid <= 1'b1;
        end else begin
          skid_data  <= push_data;
          skid_valid <= 1'b1;
        end
      end
    end
  end

  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

endmodule

FILE: rtl/force_profile_sequencer_core.sv
// force profile sequencer top level: one timer tick word in, one result word out
// result: registered in the output register, or in the skid stage behind a stalled output word
// throughput: one word per cycle while the skid stage is free, set by the phase update loop
// reset: phase 0, tick count 0, setpoint 0, registers to 0/10/5/20/40, no clearing pass
// uses fps_pkg, fps_cfg_regs, fps_seq_core, fps_out_skid
module force_profile_sequencer_core import fps_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int RAMP_STEPS  = RAMP_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // tick words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  motor_busy,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TARGET_W-1:0]   force_setpoint,
  output logic [PHASE_W-1:0]    phase,
  output logic                  speed_load,
  // register writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic [HALF_W-1:0] step;
  res_t              res_next, res_out;
  logic              accept;
  logic              skid_full;

  // a word is taken whenever the skid stage is free, so the output register
  // may hold a stalled result while the next tick is still accepted
  assign in_stall = skid_full;
  assign accept   = in_valid && !in_stall;

  // registers plus the ramp step, which is refreshed at the write itself
  fps_cfg_regs #(
    .RAMP_STEPS (RAMP_STEPS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .step      (step)
  );

  // phase, tick counter and setpoint advance once per accepted word
  fps_seq_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .RAMP_STEPS  (RAMP_STEPS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .motor_busy (motor_busy),
    .cfg        (cfg),
    .step       (step),
    .res        (res_next)
  );

  // result register and skid stage
  fps_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_next),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_out)
  );

  assign force_setpoint = res_out.force_setpoint;
  assign phase          = res_out.phase;
  assign speed_load     = res_out.speed_load;

`ifndef ASSERT_OFF
  // skid stage only fills behind a held output word
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid stage full while output register empty");

  // the speed load pulse only comes with the step into the first hold phase
  a_speed_load_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && speed_load) |-> (phase == PH_HALF_HOLD))
    else $error("speed load outside the start transition");

  // the sequencer never reports an unused phase code
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (phase <= PH_RAMP_UP))
    else $error("phase code out of range");

  // with the skid full, an output stall holds the input stalled next cycle
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (in_stall && out_stall) |=> in_stall)
    else $error("skid stage drained while output stalled");
`endif

endmodule
